// ===== src/gcdb_pkg.sv =====
// Shared types, constants and the arctangent table for the great-circle block.
// Depends on nothing; the cell files and the top level refer to it by scoped names.
package gcdb_pkg;

  localparam int unsigned CORDIC_STEPS_DEF = 24;

  // datapath widths: rotation cells, vectoring cells, vectoring angle accumulators
  localparam int unsigned RW = 34;
  localparam int unsigned VW = 36;
  localparam int unsigned ZW = 34;

  localparam logic [31:0] INV_GAIN    = 32'd652032874;
  localparam logic [31:0] PI_Q30      = 32'd3373259426;
  localparam logic [31:0] DEG_TO_TURN = 32'd1527099483;
  localparam logic [31:0] RAD_TO_TURN = 32'd1367130551;
  localparam logic [31:0] HALF_TURN   = 32'h8000_0000;
  localparam logic [31:0] QUARTER     = 32'h4000_0000;
  localparam logic [31:0] RADIUS_RST  = 32'd417529856;

  typedef struct packed {
    logic                 valid;
    logic signed [RW-1:0] x;
    logic signed [RW-1:0] y;
    logic signed [RW-1:0] z;
  } rot_t;

  typedef struct packed {
    logic                 valid;
    logic signed [VW-1:0] x;
    logic signed [VW-1:0] y;
    logic signed [ZW-1:0] z;
  } vec_t;

  // atan(2^-i) in binary angle units, 2^32 per turn, rounded to nearest
  function automatic logic [31:0] atan_turn(input int unsigned i);
    logic [31:0] a;
    case (i)
      0:  a = 32'd536870912;
      1:  a = 32'd316933406;
      2:  a = 32'd167458907;
      3:  a = 32'd85004756;
      4:  a = 32'd42667331;
      5:  a = 32'd21354465;
      6:  a = 32'd10679838;
      7:  a = 32'd5340245;
      8:  a = 32'd2670163;
      9:  a = 32'd1335087;
      10: a = 32'd667544;
      11: a = 32'd333772;
      12: a = 32'd166886;
      13: a = 32'd83443;
      14: a = 32'd41722;
      15: a = 32'd20861;
      16: a = 32'd10430;
      17: a = 32'd5215;
      18: a = 32'd2608;
      19: a = 32'd1304;
      20: a = 32'd652;
      21: a = 32'd326;
      22: a = 32'd163;
      23: a = 32'd81;
      24: a = 32'd41;
      25: a = 32'd20;
      26: a = 32'd10;
      27: a = 32'd5;
      28: a = 32'd3;
      29: a = 32'd1;
      30: a = 32'd1;
      default: a = 32'd0;
    endcase
    return a;
  endfunction

endpackage

// ===== src/gcdb_ifs.sv =====
// Channel interfaces: position pair in, distance and bearing out, radius write.
// Depends on nothing.
interface gcdb_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] local_lat;
  logic signed [31:0] local_lon;
  logic               local_is_radian;
  logic signed [31:0] remote_lat;
  logic signed [31:0] remote_lon;
  logic               remote_is_radian;
  modport source(output valid, local_lat, local_lon, local_is_radian,
                 remote_lat, remote_lon, remote_is_radian, input ready);
  modport sink(input valid, local_lat, local_lon, local_is_radian,
               remote_lat, remote_lon, remote_is_radian, output ready);
endinterface

interface gcdb_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] distance_km;
  logic [31:0] heading_deg;
  modport source(output valid, distance_km, heading_deg, input ready);
  modport sink(input valid, distance_km, heading_deg, output ready);
endinterface

interface gcdb_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] sphere_radius;
  modport source(output valid, sphere_radius, input ready);
  modport sink(input valid, sphere_radius, output ready);
endinterface

// ===== src/gcdb_rot_cell.sv =====
// One rotation-mode CORDIC step with its output register.
// Depends on gcdb_pkg.
module gcdb_rot_cell #(
  parameter int unsigned STEP = 0
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  gcdb_pkg::rot_t d_i,
  output gcdb_pkg::rot_t d_o
);

  localparam logic [31:0] ATAN32 = gcdb_pkg::atan_turn(STEP);
  localparam logic signed [gcdb_pkg::RW-1:0] ATAN =
    $signed({{(gcdb_pkg::RW-32){1'b0}}, ATAN32});

  logic signed [gcdb_pkg::RW-1:0] dx, dy, x_nxt, y_nxt, z_nxt;
  logic signed [gcdb_pkg::RW-1:0] x_r, y_r, z_r;
  logic                           valid_r;

  always_comb begin
    dx = d_i.y >>> STEP;
    dy = d_i.x >>> STEP;
    if (!d_i.z[gcdb_pkg::RW-1]) begin
      x_nxt = d_i.x - dx;
      y_nxt = d_i.y + dy;
      z_nxt = d_i.z - ATAN;
    end else begin
      x_nxt = d_i.x + dx;
      y_nxt = d_i.y - dy;
      z_nxt = d_i.z + ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= d_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  assign d_o = '{valid: valid_r, x: x_r, y: y_r, z: z_r};

endmodule

// ===== src/gcdb_vec_cell.sv =====
// One vectoring-mode CORDIC step with its output register.
// Depends on gcdb_pkg.
module gcdb_vec_cell #(
  parameter int unsigned STEP = 0
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  gcdb_pkg::vec_t d_i,
  output gcdb_pkg::vec_t d_o
);

  localparam logic [31:0] ATAN32 = gcdb_pkg::atan_turn(STEP);
  localparam logic signed [gcdb_pkg::ZW-1:0] ATAN =
    $signed({{(gcdb_pkg::ZW-32){1'b0}}, ATAN32});

  logic signed [gcdb_pkg::VW-1:0] dx, dy, x_nxt, y_nxt, x_r, y_r;
  logic signed [gcdb_pkg::ZW-1:0] z_nxt, z_r;
  logic                           valid_r;

  always_comb begin
    dx = d_i.y >>> STEP;
    dy = d_i.x >>> STEP;
    if (d_i.y[gcdb_pkg::VW-1]) begin
      x_nxt = d_i.x - dx;
      y_nxt = d_i.y + dy;
      z_nxt = d_i.z - ATAN;
    end else begin
      x_nxt = d_i.x + dx;
      y_nxt = d_i.y - dy;
      z_nxt = d_i.z + ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= d_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  assign d_o = '{valid: valid_r, x: x_r, y: y_r, z: z_r};

endmodule

// ===== src/great_circle_distance_bearing.sv =====
// Great-circle distance and initial bearing, fully pipelined CORDIC cell chains.
// Throughput: one position pair per cycle; the whole pipe holds while a result
// waits, set by the single output register and the shared advance enable.
// Reset (synchronous, rst_n low): clear all stage valids, radius to 6371 km.
// Depends on gcdb_pkg, gcdb_ifs, gcdb_rot_cell and gcdb_vec_cell.
module great_circle_distance_bearing #(
  parameter int unsigned CORDIC_STEPS = gcdb_pkg::CORDIC_STEPS_DEF
) (
  input logic       clk,
  input logic       rst_n,
  gcdb_in_if.sink   in_ch,
  gcdb_out_if.source out_ch,
  gcdb_cfg_if.sink  cfg_ch
);

  localparam int unsigned N  = CORDIC_STEPS;
  localparam int unsigned RW = gcdb_pkg::RW;
  localparam int unsigned VW = gcdb_pkg::VW;
  localparam int unsigned ZW = gcdb_pkg::ZW;

  // Whole pipe advances together; it holds only while a result is not taken.
  logic adv;
  logic out_valid_r;
  assign adv         = !out_valid_r || out_ch.ready;
  assign in_ch.ready = adv;

  // Radius register: always ready; the user is to write it between items (not enforced).
  logic [31:0] radius_r;
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= gcdb_pkg::RADIUS_RST;
    end else if (cfg_ch.valid) begin
      radius_r <= cfg_ch.sphere_radius;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: scale each angle to binary turns (product only).
  // Lanes: 0 local lat, 1 local lon, 2 remote lat, 3 remote lon.
  // ---------------------------------------------------------------------------
  logic signed [31:0] raw [0:3];
  logic        [3:0]  is_rad;
  logic signed [63:0] s1_prod_nxt [0:3];
  logic signed [63:0] s1_prod_r [0:3];
  logic        [3:0]  s1_rad_r;
  logic               s1_v_r;

  assign raw[0] = in_ch.local_lat;
  assign raw[1] = in_ch.local_lon;
  assign raw[2] = in_ch.remote_lat;
  assign raw[3] = in_ch.remote_lon;
  assign is_rad = {in_ch.remote_is_radian, in_ch.remote_is_radian,
                   in_ch.local_is_radian, in_ch.local_is_radian};

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      s1_prod_nxt[i] = raw[i] * $signed({1'b0, (is_rad[i] ? gcdb_pkg::RAD_TO_TURN
                                                           : gcdb_pkg::DEG_TO_TURN)});
    end
  end

  // Stage 2: round and take the turn bits.
  logic [63:0] s2_sum [0:3];
  logic [31:0] s2_turn_nxt [0:3];
  logic [31:0] s2_turn_r [0:3];
  logic        s2_v_r;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (s1_rad_r[i]) begin
        s2_sum[i]      = s1_prod_r[i] + 64'(1) * (64'd1 << 23);
        s2_turn_nxt[i] = s2_sum[i][55:24];
      end else begin
        s2_sum[i]      = s1_prod_r[i] + (64'd1 << 29);
        s2_turn_nxt[i] = s2_sum[i][61:30];
      end
    end
  end

  // Stage 3: longitude difference, fold each angle into [-quarter, quarter].
  function automatic logic [RW:0] fold(input logic [31:0] a);
    logic signed [RW-1:0] z;
    logic                 neg;
    z   = $signed({{(RW-32){a[31]}}, a});
    neg = 1'b0;
    if (z > $signed({{(RW-32){1'b0}}, gcdb_pkg::QUARTER})) begin
      z   = z - $signed({{(RW-32){1'b0}}, gcdb_pkg::HALF_TURN});
      neg = 1'b1;
    end else if (z < -$signed({{(RW-32){1'b0}}, gcdb_pkg::QUARTER})) begin
      z   = z + $signed({{(RW-32){1'b0}}, gcdb_pkg::HALF_TURN});
      neg = 1'b1;
    end
    return {neg, z};
  endfunction

  logic [31:0]   dlon;
  logic [RW:0]   f_lat1, f_lat2, f_dlon;
  logic signed [RW-1:0] s3_z_r [0:2];
  logic [2:0]    s3_neg_r;
  logic          s3_eq_r;
  logic          s3_v_r;

  assign dlon   = s2_turn_r[3] - s2_turn_r[1];
  assign f_lat1 = fold(s2_turn_r[0]);
  assign f_lat2 = fold(s2_turn_r[2]);
  assign f_dlon = fold(dlon);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= in_ch.valid;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_prod_r <= s1_prod_nxt;
      s1_rad_r  <= is_rad;
      s2_turn_r <= s2_turn_nxt;
      s3_z_r[0] <= f_lat1[RW-1:0];
      s3_z_r[1] <= f_lat2[RW-1:0];
      s3_z_r[2] <= f_dlon[RW-1:0];
      s3_neg_r  <= {f_dlon[RW], f_lat2[RW], f_lat1[RW]};
      s3_eq_r   <= (s2_turn_r[0] == s2_turn_r[2]) && (s2_turn_r[1] == s2_turn_r[3]);
    end
  end

  // ---------------------------------------------------------------------------
  // Three rotation chains: sine and cosine of lat1, lat2 and dlon.
  // Fold flags and the coincidence flag ride alongside, one register per cell.
  // ---------------------------------------------------------------------------
  gcdb_pkg::rot_t rc [0:2][0:N];
  logic [3:0]     rside_r [0:N-1];

  for (genvar c = 0; c < 3; c++) begin : g_rot
    assign rc[c][0] = '{valid: s3_v_r,
                        x: $signed({{(RW-32){1'b0}}, gcdb_pkg::INV_GAIN}),
                        y: '0, z: s3_z_r[c]};
    for (genvar k = 0; k < N; k++) begin : g_cell
      gcdb_rot_cell #(.STEP(k)) u_cell (
        .clk(clk), .rst_n(rst_n), .en(adv), .d_i(rc[c][k]), .d_o(rc[c][k+1])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rside_r[0] <= {s3_neg_r, s3_eq_r};
      for (int k = 1; k < N; k++) begin
        rside_r[k] <= rside_r[k-1];
      end
    end
  end

  // Stage 4: undo the fold.
  logic signed [RW-1:0] s4_c1_r, s4_s1_r, s4_c2_r, s4_s2_r, s4_cd_r, s4_sd_r;
  logic                 s4_eq_r, s4_v_r;

  // Stage 5: first products.
  logic signed [2*RW-1:0] s5_py_r, s5_pt_r;
  logic signed [RW-1:0]   s5_c1_r, s5_s1_r, s5_s2_r;
  logic                   s5_eq_r, s5_v_r;

  // Stage 6: second products.
  logic signed [RW-1:0]   t_w;
  logic signed [2*RW-1:0] s6_pa_r, s6_pb_r, s6_pc_r, s6_pd_r;
  logic signed [VW-1:0]   s6_y_r;
  logic                   s6_eq_r, s6_v_r;

  assign t_w = RW'(s5_pt_r >>> 30);

  // Stage 7: bearing terms and the clamped cosine of the central angle.
  logic signed [2*RW-1:0] dif_w, sum_w;
  logic signed [VW-1:0]   x_w;
  logic signed [2*RW-31:0] zr_w;
  logic signed [31:0]     zsat_w;
  logic signed [VW-1:0]   s7_x_r, s7_y_r;
  logic signed [31:0]     s7_z_r;
  logic                   s7_hz_r, s7_v_r;

  always_comb begin
    dif_w = s6_pa_r - s6_pb_r;
    sum_w = s6_pc_r + s6_pd_r;
    x_w   = VW'(dif_w >>> 30);
    zr_w  = (2*RW-30)'(sum_w >>> 30);
    if (zr_w > $signed({{(2*RW-62){1'b0}}, gcdb_pkg::QUARTER})) begin
      zsat_w = $signed(gcdb_pkg::QUARTER);
    end else if (zr_w < -$signed({{(2*RW-62){1'b0}}, gcdb_pkg::QUARTER})) begin
      zsat_w = -$signed(gcdb_pkg::QUARTER);
    end else begin
      zsat_w = 32'(zr_w);
    end
  end

  // Stage 8: mirror into the right half plane for the bearing vectoring.
  logic signed [VW-1:0] s8_x_r, s8_y_r;
  logic                 s8_b_r, s8_hz_r, s8_v_r;
  logic signed [31:0]   s8_z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
      s5_v_r <= 1'b0;
      s6_v_r <= 1'b0;
      s7_v_r <= 1'b0;
      s8_v_r <= 1'b0;
    end else if (adv) begin
      s4_v_r <= rc[0][N].valid;
      s5_v_r <= s4_v_r;
      s6_v_r <= s5_v_r;
      s7_v_r <= s6_v_r;
      s8_v_r <= s7_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_c1_r <= rside_r[N-1][1] ? -rc[0][N].x : rc[0][N].x;
      s4_s1_r <= rside_r[N-1][1] ? -rc[0][N].y : rc[0][N].y;
      s4_c2_r <= rside_r[N-1][2] ? -rc[1][N].x : rc[1][N].x;
      s4_s2_r <= rside_r[N-1][2] ? -rc[1][N].y : rc[1][N].y;
      s4_cd_r <= rside_r[N-1][3] ? -rc[2][N].x : rc[2][N].x;
      s4_sd_r <= rside_r[N-1][3] ? -rc[2][N].y : rc[2][N].y;
      s4_eq_r <= rside_r[N-1][0];

      s5_py_r <= s4_sd_r * s4_c2_r;
      s5_pt_r <= s4_c2_r * s4_cd_r;
      s5_c1_r <= s4_c1_r;
      s5_s1_r <= s4_s1_r;
      s5_s2_r <= s4_s2_r;
      s5_eq_r <= s4_eq_r;

      s6_y_r  <= VW'(s5_py_r >>> 30);
      s6_pa_r <= s5_c1_r * s5_s2_r;
      s6_pb_r <= s5_s1_r * t_w;
      s6_pc_r <= s5_s1_r * s5_s2_r;
      s6_pd_r <= s5_c1_r * t_w;
      s6_eq_r <= s5_eq_r;

      s7_x_r  <= x_w;
      s7_y_r  <= s6_y_r;
      s7_z_r  <= zsat_w;
      s7_hz_r <= s6_eq_r || ((x_w == '0) && (s6_y_r == '0));

      s8_b_r  <= s7_x_r[VW-1];
      s8_x_r  <= s7_x_r[VW-1] ? -s7_x_r : s7_x_r;
      s8_y_r  <= s7_x_r[VW-1] ? -s7_y_r : s7_y_r;
      s8_z_r  <= s7_z_r;
      s8_hz_r <= s7_hz_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Vectoring chain 1: bearing angle and the length of the bearing vector.
  // ---------------------------------------------------------------------------
  gcdb_pkg::vec_t vc1 [0:N];
  logic [33:0]    v1side_r [0:N-1];   // {base, coincident, clamped cosine}

  assign vc1[0] = '{valid: s8_v_r, x: s8_x_r, y: s8_y_r, z: '0};
  for (genvar k = 0; k < N; k++) begin : g_v1
    gcdb_vec_cell #(.STEP(k)) u_cell (
      .clk(clk), .rst_n(rst_n), .en(adv), .d_i(vc1[k]), .d_o(vc1[k+1])
    );
  end

  // Stage 9: bearing in turns, magnitude product.
  logic [31:0]        s9_head_r;
  logic signed [63:0] s9_mp_r;
  logic signed [31:0] s9_z_r;
  logic               s9_v_r;

  // Stage 10: set up the central-angle vectoring (cosine, sine length).
  logic signed [VW-1:0] r_w;
  logic signed [VW-1:0] s10_x_r, s10_y_r;
  logic                 s10_b_r, s10_v_r;
  logic [31:0]          s10_head_r;

  assign r_w = VW'(s9_mp_r >>> 30);

  always_ff @(posedge clk) begin
    if (adv) begin
      v1side_r[0] <= {s8_b_r, s8_hz_r, s8_z_r};
      for (int k = 1; k < N; k++) begin
        v1side_r[k] <= v1side_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s9_v_r  <= 1'b0;
      s10_v_r <= 1'b0;
    end else if (adv) begin
      s9_v_r  <= vc1[N].valid;
      s10_v_r <= s9_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // coincident points or a null bearing vector give a bearing of zero
      s9_head_r <= v1side_r[N-1][32] ? 32'd0
                 : ((v1side_r[N-1][33] ? gcdb_pkg::HALF_TURN : 32'd0)
                    + vc1[N].z[31:0]);
      s9_mp_r   <= 64'(vc1[N].x) * $signed({32'd0, gcdb_pkg::INV_GAIN});
      s9_z_r    <= $signed(v1side_r[N-1][31:0]);

      s10_b_r    <= s9_z_r[31];
      s10_x_r    <= s9_z_r[31] ? -VW'(s9_z_r) : VW'(s9_z_r);
      s10_y_r    <= s9_z_r[31] ? -r_w : r_w;
      s10_head_r <= s9_head_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Vectoring chain 2: central angle atan2(length, cosine).
  // ---------------------------------------------------------------------------
  gcdb_pkg::vec_t vc2 [0:N];
  logic [32:0]    v2side_r [0:N-1];   // {base, bearing}

  assign vc2[0] = '{valid: s10_v_r, x: s10_x_r, y: s10_y_r, z: '0};
  for (genvar k = 0; k < N; k++) begin : g_v2
    gcdb_vec_cell #(.STEP(k)) u_cell (
      .clk(clk), .rst_n(rst_n), .en(adv), .d_i(vc2[k]), .d_o(vc2[k+1])
    );
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      v2side_r[0] <= {s10_b_r, s10_head_r};
      for (int k = 1; k < N; k++) begin
        v2side_r[k] <= v2side_r[k-1];
      end
    end
  end

  // Stage 11: absolute central angle in turns.
  logic [31:0] cang_w;
  logic [32:0] s11_cs_r;
  logic [31:0] s11_head_r;
  logic        s11_v_r;

  assign cang_w = (v2side_r[N-1][32] ? gcdb_pkg::HALF_TURN : 32'd0) + vc2[N].z[31:0];

  // Stage 12: angle to radians; stage 13: radians times radius.
  logic [63:0] s12_prad_r;
  logic [31:0] s12_head_r;
  logic        s12_v_r;
  logic [64:0] rad_sum_w;
  logic [31:0] rad_w;
  logic [63:0] s13_pd_r;
  logic [31:0] s13_head_r;
  logic        s13_v_r;

  assign rad_sum_w = {1'b0, s12_prad_r} + (65'd1 << 30);
  assign rad_w     = rad_sum_w[62:31];

  // Output stage: round, saturate, scale bearing by 360.
  logic [64:0] dist_sum_w;
  logic [37:0] head_x45_w;
  logic [31:0] dist_r, heading_r;

  assign dist_sum_w = {1'b0, s13_pd_r} + (65'd1 << 29);
  assign head_x45_w = {6'd0, s13_head_r} * 38'd45;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s11_v_r     <= 1'b0;
      s12_v_r     <= 1'b0;
      s13_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s11_v_r     <= vc2[N].valid;
      s12_v_r     <= s11_v_r;
      s13_v_r     <= s12_v_r;
      out_valid_r <= s13_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s11_cs_r   <= cang_w[31] ? (33'h1_0000_0000 - {1'b0, cang_w}) : {1'b0, cang_w};
      s11_head_r <= v2side_r[N-1][31:0];

      s12_prad_r <= 64'(s11_cs_r) * 64'(gcdb_pkg::PI_Q30);
      s12_head_r <= s11_head_r;

      s13_pd_r   <= 64'(radius_r) * 64'(rad_w);
      s13_head_r <= s12_head_r;

      dist_r     <= (dist_sum_w[64:62] != 3'd0) ? 32'hFFFF_FFFF : dist_sum_w[61:30];
      heading_r  <= head_x45_w[37:6];
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.distance_km = dist_r;
  assign out_ch.heading_deg = heading_r;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid_r)
    else $error("result valid set straight after reset");

  a_heading_below_360: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (heading_r < 32'd3019898880))
    else $error("bearing reached 360 degrees");

  a_stall_holds_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |=> (s13_v_r == $past(s13_v_r)))
    else $error("pipe moved while a result was held");

endmodule
